[rtl/core/es2cd_pkg.sv]
// Shared constants, types and calendar helper functions for the epoch-to-date converter.
package es2cd_pkg;

  // Number of register stages between the input and the output word.
  localparam int NumStages = 8;

  // Seconds per day split as 675 * 2^7; the low 7 bits pass straight through.
  localparam int         DayLowBits = 7;
  localparam logic [9:0] DayHigh    = 10'd675;

  // Reciprocal multipliers. Each pair gives floor(x / d) as (x * Recip) >> Shift.
  // The day reciprocal is rounded down and may come out one low; a compare fixes it.
  // The others are rounded up and are exact over the input ranges that reach them.
  localparam logic [25:0] DayRecip  = 26'd50903316;
  localparam int          DayShift  = 35;
  localparam logic [15:0] HourRecip = 16'd37283;
  localparam int          HourShift = 27;
  localparam logic [11:0] MinRecip  = 12'd2185;
  localparam int          MinShift  = 17;
  localparam logic [16:0] WeekRecip = 17'd74899;
  localparam int          WeekShift = 19;
  localparam logic [15:0] YearRecip = 16'd45965;
  localparam int          YearShift = 24;

  localparam logic [11:0] SecsPerHour  = 12'd3600;
  localparam logic [5:0]  SecsPerMin   = 6'd60;
  localparam logic [2:0]  DaysPerWeek  = 3'd7;
  localparam logic [2:0]  EpochWeekday = 3'd4;
  localparam logic [8:0]  DaysPerYear  = 9'd365;

  // Year offsets are counted from 1970.
  localparam logic [7:0] EpochYearOff   = 8'd70;
  localparam logic [7:0] CenturyYearOff = 8'd130;

  typedef struct packed {
    logic [NumStages-1:0] en;
    logic [NumStages-1:0] vld;
  } pipe_ctl_t;

  // Leap years among 1970 .. 1970+yoff-1. The year 2000 is a leap year and 2100 is not.
  function automatic logic [5:0] leaps_before(input logic [7:0] yoff);
    logic [8:0] quarter;
    logic       skip;
    quarter = (9'(yoff) + 9'd1) >> 2;
    skip    = (yoff > CenturyYearOff);
    return 6'(quarter - 9'(skip));
  endfunction

  function automatic logic is_leap(input logic [7:0] yoff);
    return (yoff[1:0] == 2'd2) && (yoff != CenturyYearOff);
  endfunction

  // Zero-based day of year on which a month starts.
  function automatic logic [8:0] month_start(input logic [3:0] mon, input logic leap);
    logic [8:0] base;
    case (mon)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + 9'(leap && (mon >= 4'd2));
  endfunction

endpackage

[rtl/core/epoch_seconds_to_calendar_date_top.sv]
// Top level of the epoch-seconds to Gregorian calendar date converter.
// Throughput is one word per cycle; each of the 8 stages holds its word under
// backpressure and empty stages fill up, so in_ready drops only when all are full.
// Reset (rst, synchronous) clears every stage valid bit; the data path is not reset.
// There is no stored state besides the words in flight.
module epoch_seconds_to_calendar_date_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] epoch_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  second,
  output logic [5:0]  minute,
  output logic [4:0]  hour,
  output logic [2:0]  weekday,
  output logic [7:0]  years_since_1900,
  output logic [8:0]  day_of_year,
  output logic [3:0]  month_index,
  output logic [4:0]  day_of_month
);
  import es2cd_pkg::*;

  pipe_ctl_t ctl;

  es2cd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  // Stage 1: the day count is the input over 86400. The low 7 bits of the input
  // are the low bits of the seconds of day; the rest is divided by 675 with a
  // reciprocal multiply.
  logic [6:0]  s1_tlo;
  logic [24:0] s1_x;
  logic [50:0] s1_prod;

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      s1_tlo  <= epoch_seconds[DayLowBits-1:0];
      s1_x    <= epoch_seconds[31:DayLowBits];
      s1_prod <= 51'(epoch_seconds[31:DayLowBits]) * 51'(DayRecip);
    end
  end

  // Stage 2: the quotient estimate may be one short, so the partial remainder
  // can reach just under twice 675.
  logic [6:0]  s2_tlo;
  logic [15:0] s2_q;
  logic [10:0] s2_r;
  logic [15:0] q_est;
  logic [25:0] q_times;

  assign q_est   = s1_prod[50:DayShift];
  assign q_times = 26'(q_est) * 26'(DayHigh);

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      s2_tlo <= s1_tlo;
      s2_q   <= q_est;
      s2_r   <= 11'(26'(s1_x) - q_times);
    end
  end

  // Stage 3: one compare and subtract settles the day count and the seconds of day.
  logic [15:0] s3_days;
  logic [16:0] s3_sod;
  logic        r_over;
  logic [10:0] r_fix;

  assign r_over = (s2_r >= 11'(DayHigh));
  assign r_fix  = r_over ? (s2_r - 11'(DayHigh)) : s2_r;

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      s3_days <= s2_q + 16'(r_over);
      s3_sod  <= {r_fix[9:0], s2_tlo};
    end
  end

  // Stage 4: three reciprocal multiplies in parallel give the hour, the number
  // of whole weeks since the epoch Thursday offset, and a year estimate.
  logic [4:0]  s4_hour;
  logic [12:0] s4_q7;
  logic [7:0]  s4_yoff;
  logic [15:0] s4_days;
  logic [16:0] s4_sod;
  logic [15:0] days_wk;
  logic [31:0] hprod;
  logic [31:0] wprod;
  logic [31:0] yprod;

  assign days_wk = s3_days + 16'(EpochWeekday);
  assign hprod   = 32'(s3_sod) * 32'(HourRecip);
  assign wprod   = 32'(days_wk) * 32'(WeekRecip);
  assign yprod   = 32'(s3_days) * 32'(YearRecip);

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      s4_hour <= hprod[HourShift+4:HourShift];
      s4_q7   <= wprod[WeekShift+12:WeekShift];
      s4_yoff <= yprod[YearShift+7:YearShift];
      s4_days <= s3_days;
      s4_sod  <= s3_sod;
    end
  end

  // Stage 5: remainders. The year estimate ignores leap days, so the day of
  // year left over can be slightly negative, never below minus the leap count.
  logic [11:0]       s5_remh;
  logic [2:0]        s5_wd;
  logic signed [9:0] s5_dr;
  logic [7:0]        s5_yoff;
  logic [4:0]        s5_hour;
  logic [16:0]       h_secs;
  logic [15:0]       wk_days;
  logic [16:0]       y_days;
  logic [17:0]       dr_calc;

  assign h_secs  = 17'(s4_hour) * 17'(SecsPerHour);
  assign wk_days = 16'(s4_q7) * 16'(DaysPerWeek);
  assign y_days  = 17'(s4_yoff) * 17'(DaysPerYear);
  assign dr_calc = 18'(s4_days) - 18'(y_days) - 18'(leaps_before(s4_yoff));

  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      s5_remh <= 12'(s4_sod - h_secs);
      s5_wd   <= 3'(s4_days + 16'(EpochWeekday) - wk_days);
      s5_dr   <= dr_calc[9:0];
      s5_yoff <= s4_yoff;
      s5_hour <= s4_hour;
    end
  end

  // Stage 6: step the year back once when the estimate overshot, and split
  // the seconds of the hour into minutes.
  logic [5:0]  s6_minute;
  logic [11:0] s6_remh;
  logic [7:0]  s6_year;
  logic        s6_leap;
  logic [8:0]  s6_doy0;
  logic [4:0]  s6_hour;
  logic [2:0]  s6_wd;
  logic        overshoot;
  logic [7:0]  year_fix;
  logic        leap_fix;
  logic [9:0]  doy_fix;
  logic [23:0] mprod;

  assign overshoot = s5_dr[9];
  assign year_fix  = overshoot ? (s5_yoff - 8'd1) : s5_yoff;
  assign leap_fix  = is_leap(year_fix);
  assign doy_fix   = overshoot ? (10'(s5_dr) + 10'(DaysPerYear) + 10'(leap_fix))
                               : 10'(s5_dr);
  assign mprod     = 24'(s5_remh) * 24'(MinRecip);

  always_ff @(posedge clk) begin
    if (ctl.en[5]) begin
      s6_minute <= mprod[MinShift+5:MinShift];
      s6_remh   <= s5_remh;
      s6_year   <= year_fix;
      s6_leap   <= leap_fix;
      s6_doy0   <= doy_fix[8:0];
      s6_hour   <= s5_hour;
      s6_wd     <= s5_wd;
    end
  end

  // Stage 7: the month is found by comparing the day of year against all
  // month start days at once; the starts rise, so the last match wins.
  logic [5:0] s7_second;
  logic [5:0] s7_minute;
  logic [3:0] s7_month;
  logic [7:0] s7_year;
  logic       s7_leap;
  logic [8:0] s7_doy0;
  logic [4:0] s7_hour;
  logic [2:0] s7_wd;
  logic [3:0] mon_sel;
  logic [11:0] m_secs;

  always_comb begin
    mon_sel = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (s6_doy0 >= month_start(4'(m), s6_leap)) begin
        mon_sel = 4'(m);
      end
    end
  end

  assign m_secs = 12'(s6_minute) * 12'(SecsPerMin);

  always_ff @(posedge clk) begin
    if (ctl.en[6]) begin
      s7_second <= 6'(s6_remh - m_secs);
      s7_minute <= s6_minute;
      s7_month  <= mon_sel;
      s7_year   <= s6_year;
      s7_leap   <= s6_leap;
      s7_doy0   <= s6_doy0;
      s7_hour   <= s6_hour;
      s7_wd     <= s6_wd;
    end
  end

  // Stage 8: output registers. Day of year and day of month count from one.
  always_ff @(posedge clk) begin
    if (ctl.en[7]) begin
      second           <= s7_second;
      minute           <= s7_minute;
      hour             <= s7_hour;
      weekday          <= s7_wd;
      years_since_1900 <= s7_year + EpochYearOff;
      day_of_year      <= s7_doy0 + 9'd1;
      month_index      <= s7_month;
      day_of_month     <= 5'(s7_doy0 - month_start(s7_month, s7_leap) + 9'd1);
    end
  end

endmodule

[rtl/core/es2cd_ctrl.sv]
// Valid and stall control for the converter pipeline.
module es2cd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output es2cd_pkg::pipe_ctl_t  ctl
);
  import es2cd_pkg::*;

  logic [NumStages-1:0] vld;
  logic [NumStages-1:0] en;

  // A stage loads when it is empty or when its word moves on this cycle.
  always_comb begin
    en[NumStages-1] = !vld[NumStages-1] || out_ready;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NumStages-1];
  assign ctl.en    = en;
  assign ctl.vld   = vld;

`ifndef SYNTHESIS
  // With the last stage empty nothing can hold back the input.
  a_empty_tail_ready: assert property (@(posedge clk) disable iff (rst)
    !vld[NumStages-1] |-> in_ready)
    else $error("input stalled while the last stage is empty");

  // A word that is not taken stays in the last stage.
  a_tail_held: assert property (@(posedge clk) disable iff (rst)
    (vld[NumStages-1] && !out_ready) |=> vld[NumStages-1])
    else $error("stalled output word was dropped");

  // An accepted input with no output taken adds exactly one word in flight.
  a_fill_count: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !(out_valid && out_ready))
      |=> ($countones(vld) == $past($countones(vld)) + 1))
    else $error("word count in the pipeline is off");
`endif

endmodule
